// ===== hw/rtl/chacha_pkg.sv =====
// shared types, constants and round functions of the chacha20 stream cipher
`timescale 1ns / 1ps

package chacha_pkg;

    localparam int ROUND_COUNT_DEF    = 20;
    localparam int BYTES_PER_ITEM_DEF = 8;
    localparam int BLOCK_BYTES        = 64;
    localparam int QUEUE_DEPTH        = 4;
    // wide enough for the item position at one byte per item
    localparam int POS_W              = 6;
    localparam int CFG_IDX_W          = 3;

    typedef logic [31:0]       t_word;
    typedef logic [15:0][31:0] t_words;
    typedef logic [3:0][31:0]  t_quad;

    // "expand 32-byte k"
    localparam t_word SIGMA_0 = 32'h6170_7865;
    localparam t_word SIGMA_1 = 32'h3320_646e;
    localparam t_word SIGMA_2 = 32'h7962_2d32;
    localparam t_word SIGMA_3 = 32'h6b20_6574;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_KEY_01      = 3'd0;
    localparam t_cfg_idx CFG_KEY_23      = 3'd1;
    localparam t_cfg_idx CFG_KEY_45      = 3'd2;
    localparam t_cfg_idx CFG_KEY_67      = 3'd3;
    localparam t_cfg_idx CFG_START_COUNT = 3'd4;
    localparam t_cfg_idx CFG_NONCE_01    = 3'd5;
    localparam t_cfg_idx CFG_NONCE_2     = 3'd6;

    typedef struct packed {
        logic [63:0] data_in;
        logic [3:0]  byte_count;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] data_out;
        logic [3:0]  out_byte_count;
        logic        out_last;
    } t_out_item;

    typedef struct packed {
        logic [7:0][31:0] key;
        logic [2:0][31:0] nonce;
    } t_cipher_cfg;

    // one queued item with its place in the keystream
    typedef struct packed {
        t_in_item         item;
        logic [POS_W-1:0] pos;
        logic             need_block;
        t_word            counter;
    } t_job;

    typedef struct packed {
        logic  start;
        t_word counter;
    } t_core_req;

    typedef struct packed {
        logic   done;
        t_words block;
    } t_core_rsp;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_GEN,
        BK_HOLD
    } t_back_state;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINISH
    } t_core_state;

    function automatic t_word rotl(input t_word v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // q[0..3] = a, b, c, d
    function automatic t_quad quarter(input t_quad q);
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_quad r;
        a = q[0];
        b = q[1];
        c = q[2];
        d = q[3];
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        r[0] = a;
        r[1] = b;
        r[2] = c;
        r[3] = d;
        return r;
    endfunction

    // one column round, or one diagonal round when diag is set
    function automatic t_words chacha_round(input t_words x, input logic diag);
        t_words y;
        t_quad  q;
        y = x;
        for (int i = 0; i < 4; i++) begin
            if (!diag) begin
                q = quarter({x[12 + i], x[8 + i], x[4 + i], x[i]});
                y[i]      = q[0];
                y[4 + i]  = q[1];
                y[8 + i]  = q[2];
                y[12 + i] = q[3];
            end else begin
                q = quarter({x[12 + ((i + 3) & 3)], x[8 + ((i + 2) & 3)],
                             x[4 + ((i + 1) & 3)], x[i]});
                y[i]                  = q[0];
                y[4 + ((i + 1) & 3)]  = q[1];
                y[8 + ((i + 2) & 3)]  = q[2];
                y[12 + ((i + 3) & 3)] = q[3];
            end
        end
        return y;
    endfunction

    function automatic t_words init_words(input t_cipher_cfg cfg, input t_word counter);
        t_words w;
        w[0] = SIGMA_0;
        w[1] = SIGMA_1;
        w[2] = SIGMA_2;
        w[3] = SIGMA_3;
        for (int i = 0; i < 8; i++) begin
            w[4 + i] = cfg.key[i];
        end
        w[12] = counter;
        w[13] = cfg.nonce[0];
        w[14] = cfg.nonce[1];
        w[15] = cfg.nonce[2];
        return w;
    endfunction

endpackage

// ===== hw/rtl/chacha20_stream_cipher.sv =====
// top level of the chacha20 stream cipher: configuration registers and the front/back pipeline
// XORs a message with the chacha keystream, up to eight bytes per transaction. Load key,
// nonce and start counter through the config port while nothing is in flight; the counter
// is reloaded at the first transaction after reset or after a last one. An item that opens
// a new 64-byte keystream block waits for the single iterated round unit (load, one round
// per cycle, then the final add); the other items of that block leave one per cycle while the
// consumer keeps up. A four-entry queue lets input transactions keep arriving while a block
// is being made, and a result register lets the next item be processed while the previous
// result waits for the consumer. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module chacha20_stream_cipher import chacha_pkg::*; #(
    parameter int ROUND_COUNT    = ROUND_COUNT_DEF,
    parameter int BYTES_PER_ITEM = BYTES_PER_ITEM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cipher_cfg r_cfg;
    t_word       r_start_count;

    logic        w_push;
    t_job        w_job;
    logic        w_full;
    logic        w_pop;
    logic        w_head_valid;
    t_job        w_head;
    t_core_req   w_core_req;
    t_core_rsp   w_core_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= '0;
            r_start_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_01:      r_cfg.key[1:0]   <= i_cfg_data;
                CFG_KEY_23:      r_cfg.key[3:2]   <= i_cfg_data;
                CFG_KEY_45:      r_cfg.key[5:4]   <= i_cfg_data;
                CFG_KEY_67:      r_cfg.key[7:6]   <= i_cfg_data;
                CFG_START_COUNT: r_start_count    <= i_cfg_data[31:0];
                CFG_NONCE_01:    r_cfg.nonce[1:0] <= i_cfg_data;
                CFG_NONCE_2:     r_cfg.nonce[2]   <= i_cfg_data[31:0];
                default:         r_start_count    <= r_start_count;
            endcase
        end
    end

    chacha_front #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .i_start_count (r_start_count),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_job         (w_job)
    );

    chacha_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_job        (w_job),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    chacha_round_engine #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (w_core_req),
        .o_rsp   (w_core_rsp)
    );

    chacha_back #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_core_req   (w_core_req),
        .i_core_rsp   (w_core_rsp),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

// ===== hw/rtl/chacha_front.sv =====
// front end: accepts items and tags each with its keystream position and block counter
`timescale 1ns / 1ps

module chacha_front import chacha_pkg::*; #(
    parameter int BYTES_PER_ITEM = BYTES_PER_ITEM_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  t_word    i_start_count,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_job
);

    localparam int ITEMS  = BLOCK_BYTES / BYTES_PER_ITEM;
    localparam int WPOS_W = (ITEMS > 1) ? $clog2(ITEMS) : 1;
    localparam logic [WPOS_W-1:0] LAST_POS = WPOS_W'(ITEMS - 1);

    logic [WPOS_W-1:0] r_wpos;
    logic [WPOS_W-1:0] n_wpos;
    logic              r_in_msg;
    logic              n_in_msg;
    t_word             r_blk_cnt;
    t_word             n_blk_cnt;

    logic              w_accept;
    logic [WPOS_W-1:0] w_pos;
    t_word             w_cnt;
    logic              w_wrap;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    // the first item of a message restarts from the configured counter
    assign w_pos  = r_in_msg ? r_wpos : '0;
    assign w_cnt  = r_in_msg ? r_blk_cnt : i_start_count;
    assign w_wrap = (w_pos == LAST_POS);

    assign o_push          = w_accept;
    assign o_job.item      = i_in_item;
    assign o_job.pos       = POS_W'(w_pos);
    assign o_job.need_block = (w_pos == '0);
    assign o_job.counter   = w_cnt;

    always_comb begin
        n_wpos    = r_wpos;
        n_in_msg  = r_in_msg;
        n_blk_cnt = r_blk_cnt;
        if (w_accept) begin
            if (i_in_item.last) begin
                n_wpos   = '0;
                n_in_msg = 1'b0;
            end else begin
                n_in_msg  = 1'b1;
                n_wpos    = w_wrap ? '0 : w_pos + 1'b1;
                n_blk_cnt = w_wrap ? w_cnt + 1'b1 : w_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos    <= '0;
            r_in_msg  <= 1'b0;
            r_blk_cnt <= '0;
        end else begin
            r_wpos    <= n_wpos;
            r_in_msg  <= n_in_msg;
            r_blk_cnt <= n_blk_cnt;
        end
    end

endmodule

// ===== hw/rtl/chacha_queue.sv =====
// short job queue between the front end and the back end
`timescale 1ns / 1ps

module chacha_queue import chacha_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_job o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign o_full       = (r_cnt == FULL_CNT);
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/chacha_core.sv =====
// iterated chacha block function, one round per cycle
`timescale 1ns / 1ps

module chacha_round_engine import chacha_pkg::*; #(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cipher_cfg i_cfg,
    input  t_core_req   i_req,
    output t_core_rsp   o_rsp
);

    localparam int RND_W = $clog2(ROUND_COUNT);
    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUND_COUNT - 1);

    t_core_state      r_state;
    t_core_state      n_state;
    t_words           r_x;
    t_word            r_ctr;
    logic [RND_W-1:0] r_round;
    t_words           w_init;

    // the user must keep key and nonce put while any item is in flight; the block does not enforce it
    assign w_init = init_words(i_cfg, r_ctr);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CORE_IDLE:   if (i_req.start) n_state = CORE_ROUND;
            CORE_ROUND:  if (r_round == LAST_RND) n_state = CORE_FINISH;
            CORE_FINISH: n_state = CORE_IDLE;
            default:     n_state = CORE_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == CORE_FINISH);
        for (int i = 0; i < 16; i++) begin
            o_rsp.block[i] = r_x[i] + w_init[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CORE_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == CORE_IDLE) begin
                r_round <= '0;
            end else if (r_state == CORE_ROUND) begin
                r_round <= r_round + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == CORE_IDLE && i_req.start) begin
            r_x   <= init_words(i_cfg, i_req.counter);
            r_ctr <= i_req.counter;
        end else if (r_state == CORE_ROUND) begin
            // even rounds are column rounds, odd ones diagonal
            r_x <= chacha_round(r_x, r_round[0]);
        end
    end

endmodule

// ===== hw/rtl/chacha_back.sv =====
// back end: fetches keystream blocks, xors items and holds the result register
`timescale 1ns / 1ps

module chacha_back import chacha_pkg::*; #(
    parameter int BYTES_PER_ITEM = BYTES_PER_ITEM_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_job      i_head,
    output logic      o_pop,
    output t_core_req o_core_req,
    input  t_core_rsp i_core_rsp,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int LIMIT = (BYTES_PER_ITEM < 8) ? BYTES_PER_ITEM : 8;
    localparam logic [6:0] BPI_W = 7'(BYTES_PER_ITEM);

    t_back_state  r_state;
    t_back_state  n_state;
    t_words       r_block;
    logic         r_out_valid;
    t_out_item    r_out;

    logic         w_out_free;
    logic         w_start;
    logic         w_emit;
    logic [12:0]  w_base_full;
    logic [5:0]   w_base;
    logic [575:0] w_padded;
    logic [63:0]  w_window;
    logic [63:0]  w_mixed;
    logic [3:0]   w_valid_n;
    t_out_item    w_result;

    assign w_out_free = !r_out_valid || i_out_ready;

    // byte offset of this item inside the 64-byte block
    assign w_base_full = {7'b0, i_head.pos} * {6'b0, BPI_W};
    assign w_base      = w_base_full[5:0];
    assign w_padded    = {64'b0, r_block};
    assign w_window    = w_padded[{w_base, 3'b000} +: 64];
    assign w_mixed     = i_head.item.data_in ^ w_window;

    assign w_valid_n = (i_head.item.byte_count > 4'(LIMIT)) ? 4'(LIMIT)
                                                             : i_head.item.byte_count;

    for (genvar k = 0; k < 8; k++) begin : g_byte
        assign w_result.data_out[8*k +: 8] = (4'(k) < w_valid_n) ? w_mixed[8*k +: 8] : 8'h00;
    end
    assign w_result.out_byte_count = i_head.item.byte_count;
    assign w_result.out_last       = i_head.item.last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_head_valid && i_head.need_block) n_state = BK_GEN;
            BK_GEN:  if (i_core_rsp.done) n_state = BK_HOLD;
            BK_HOLD: if (w_out_free) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        w_start = 1'b0;
        w_emit  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                w_start = i_head_valid && i_head.need_block;
                w_emit  = i_head_valid && !i_head.need_block && w_out_free;
            end
            BK_HOLD: w_emit = w_out_free;
            default: begin
                w_start = 1'b0;
                w_emit  = 1'b0;
            end
        endcase
    end

    assign o_pop              = w_emit;
    assign o_core_req.start   = w_start;
    assign o_core_req.counter = i_head.counter;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_GEN && i_core_rsp.done) begin
            r_block <= i_core_rsp.block;
        end
        if (w_emit) begin
            r_out <= w_result;
        end
    end

`ifndef SYNTHESIS
    a_done_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_core_rsp.done |-> r_state == BK_GEN)
        else $error("core finished a block that was not requested");

    a_hold_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_HOLD |-> i_head_valid)
        else $error("fresh keystream block without a waiting item");

    a_no_stale_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE && i_head_valid && i_head.need_block) |-> !o_pop)
        else $error("item xored with an old keystream block");

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_valid)
        else $error("pop from an empty queue");

    a_start_to_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_core_req.start |=> r_state == BK_GEN)
        else $error("block request lost");
`endif

endmodule
